@@ design/sngx_pkg.sv @@
// Shared constants, types and a helper function of the sparse n-gram span extractor.
`timescale 1ns / 1ps
`default_nettype none
package sngx_pkg;

  localparam int MAX_GRAM    = 16;
  localparam int OFFSET_BITS = 16;

  localparam int LEN_W      = $clog2(MAX_GRAM + 1);
  localparam int POS_W      = OFFSET_BITS + 1;
  localparam int BASE_W     = OFFSET_BITS + 2;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int DENS_W     = 10;

  // Result slots in delivery order: UTF-8 flush, single gram, sparse
  // retirements from longest to shortest, boundary gram, end-of-value flush.
  localparam int SLOT_SINGLE = 3;
  localparam int SLOT_RET0   = 4;
  localparam int SLOT_BOUND  = SLOT_RET0 + MAX_GRAM;
  localparam int SLOT_F2     = SLOT_BOUND + 1;
  localparam int NUM_SLOTS   = SLOT_F2 + 3;

  localparam logic [63:0] MIX_C1    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2    = 64'h94d049bb133111eb;
  localparam logic [31:0] PAIR_SALT = 32'h5bd1e995;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAM_MODE  = 3'd0,
    REG_MIN_LENGTH = 3'd1,
    REG_MAX_LENGTH = 3'd2,
    REG_DENSITY    = 3'd3,
    REG_FOLD_CASE  = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    HOP_NONE = 3'd0,
    HOP_M0   = 3'd1,
    HOP_M1   = 3'd2,
    HOP_M2   = 3'd3,
    HOP_M3   = 3'd4,
    HOP_M4   = 3'd5,
    HOP_CMP  = 3'd6
  } hash_op_t;

  typedef struct packed {
    logic     latch;
    hash_op_t hop;
    logic     calc;
    logic     emit;
  } sngx_cmd_t;

  typedef struct packed {
    logic need_hash;
    logic slots_empty;
    logic slots_one;
    logic out_free;
  } sngx_sts_t;

  // Length of the UTF-8 sequence that a lead byte opens; 1 for anything else.
  function automatic logic [CNT_W-1:0] seq_len(input logic [7:0] c);
    logic [CNT_W-1:0] r;
    begin
      if (c[7] == 1'b0) r = 3'd1;
      else if (c[7:5] == 3'b110) r = 3'd2;
      else if (c[7:4] == 4'b1110) r = 3'd3;
      else if (c[7:3] == 5'b11110) r = 3'd4;
      else r = 3'd1;
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ design/sngx_ctrl.sv @@
// Controller state machine that sequences hashing, step evaluation and result delivery.
`timescale 1ns / 1ps
`default_nettype none
module sngx_ctrl
  import sngx_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire sngx_sts_t sts,
  output sngx_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_M0   = 9'b000000010,
    S_M1   = 9'b000000100,
    S_M2   = 9'b000001000,
    S_M3   = 9'b000010000,
    S_M4   = 9'b000100000,
    S_CMP  = 9'b001000000,
    S_CALC = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '{latch: 1'b0, hop: HOP_NONE, calc: 1'b0, emit: 1'b0};
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = sts.need_hash ? S_M0 : S_CALC;
        end
      end
      S_M0: begin
        cmd.hop   = HOP_M0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.hop   = HOP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.hop   = HOP_M2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.hop   = HOP_M3;
        state_nxt = S_M4;
      end
      S_M4: begin
        cmd.hop   = HOP_M4;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.hop   = HOP_CMP;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free && !sts.slots_empty;
        if (sts.slots_empty || (sts.out_free && sts.slots_one)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/sngx_dp.sv @@
// Datapath: configuration, text state, pair hash, step evaluation and result register.
`timescale 1ns / 1ps
`default_nettype none
module sngx_dp
  import sngx_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sngx_cmd_t             cmd,
  output sngx_sts_t                  sts,
  input  wire logic [7:0]            in_text_byte,
  input  wire logic                  in_end_of_value,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OFFSET_BITS-1:0]     out_gram_start,
  output logic [LEN_W-1:0]           out_gram_length,
  output logic                       out_offset_overflow,
  output logic                       out_last_of_run
);

  // Configuration registers.
  logic              mode_r;
  logic [4:0]        min_len_r;
  logic [4:0]        max_len_r;
  logic [DENS_W-1:0] dens_r;
  logic              fold_r;

  // Text state.
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [LEN_W-1:0]    seg_r, seg_nxt;
  logic [MAX_GRAM-1:0] hist_r, hist_nxt;
  logic [7:0]          prev_r, prev_nxt;
  logic [MAX_GRAM:0]   pend_r, pend_nxt;
  logic [CNT_W-1:0]    ucnt_r, ucnt_nxt;
  logic [CNT_W-1:0]    uneed_r, uneed_nxt;

  // Latched item and hash.
  logic [7:0]  c_r;
  logic        eov_r;
  logic [63:0] acc1_r, acc2_r;
  logic        bnd_r;

  // Pending results of the current step.
  logic [NUM_SLOTS-1:0] slots_r, slots_nxt;
  logic [CNT_W-1:0]     k1_r, k1_nxt, k2_r, k2_nxt;
  logic [LEN_W-1:0]     sb_r, sb_nxt, sl_r, sl_nxt;
  logic [POS_W-1:0]     step_pos_r;

  // Output register.
  logic                   out_valid_r;
  logic [OFFSET_BITS-1:0] out_start_r;
  logic [LEN_W-1:0]       out_len_r;
  logic                   out_ovf_r;
  logic                   out_last_r;

  // A write to any defined register empties the open sparse starts.
  logic cfg_hit;
  assign cfg_hit = cfg_valid && (cfg_index inside {REG_GRAM_MODE, REG_MIN_LENGTH,
                                                   REG_MAX_LENGTH, REG_DENSITY,
                                                   REG_FOLD_CASE});

  // Effective lengths.
  logic [LEN_W-1:0] n_eff, mx_eff, mn_ext, mx_ext;

  always_comb begin
    mn_ext = LEN_W'(min_len_r);
    mx_ext = LEN_W'(max_len_r);
    n_eff  = mn_ext;
    if (mn_ext == '0) n_eff = LEN_W'(1);
    if (mn_ext > LEN_W'(MAX_GRAM)) n_eff = LEN_W'(MAX_GRAM);
    mx_eff = mx_ext;
    if (mx_ext == '0) mx_eff = LEN_W'(1);
    if (mx_ext > LEN_W'(MAX_GRAM)) mx_eff = LEN_W'(MAX_GRAM);
    if (mx_eff < n_eff) mx_eff = n_eff;
  end

  logic [7:0] c_in;
  always_comb begin
    c_in = in_text_byte;
    if (fold_r && (in_text_byte inside {[8'h41:8'h5A]})) c_in = in_text_byte + 8'd32;
  end

  // Pair hash: a 64-bit finalizer built from one shared 32x32 multiplier.
  logic [31:0] key, x1, mul_a, mul_b;
  logic [63:0] prod, x2;
  logic [15:0] hval;
  logic [16:0] hp1;
  logic [26:0] lhs, rhs;

  always_comb begin
    key = {16'd0, prev_r, c_r} ^ PAIR_SALT;
    x1  = key ^ {30'd0, key[31:30]};
    x2  = acc1_r ^ (acc1_r >> 27);
    case (cmd.hop)
      HOP_M0: begin
        mul_a = x1;
        mul_b = MIX_C1[31:0];
      end
      HOP_M1: begin
        mul_a = x1;
        mul_b = MIX_C1[63:32];
      end
      HOP_M2: begin
        mul_a = x2[31:0];
        mul_b = MIX_C2[31:0];
      end
      HOP_M3: begin
        mul_a = x2[31:0];
        mul_b = MIX_C2[63:32];
      end
      HOP_M4: begin
        mul_a = x2[63:32];
        mul_b = MIX_C2[31:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = {32'd0, mul_a} * {32'd0, mul_b};
    hval = acc2_r[15:0] ^ acc2_r[46:31];
    hp1  = {1'b0, hval} + 17'd1;
    // h < floor(d * 65536 / 1000) is the same as (h + 1) * 1000 <= d * 65536.
    lhs  = 27'(hp1) * 27'd1000;
    rhs  = 27'({dens_r, 16'd0});
  end

  always_ff @(posedge clk) begin
    case (cmd.hop)
      HOP_M0: acc1_r <= prod;
      HOP_M1: acc1_r <= acc1_r + {prod[31:0], 32'd0};
      HOP_M2: acc2_r <= prod;
      HOP_M3: acc2_r <= acc2_r + {prod[31:0], 32'd0};
      HOP_M4: acc2_r <= acc2_r + {prod[31:0], 32'd0};
      HOP_CMP: bnd_r <= (lhs <= rhs);
      default: begin
      end
    endcase
    if (cmd.latch) begin
      c_r   <= c_in;
      eov_r <= in_end_of_value;
    end
  end

  // Step evaluation.
  logic [MAX_GRAM:0]   nw;
  logic [MAX_GRAM-1:0] hist_sh;
  logic [MAX_GRAM:0]   psh, ret;
  logic                handled;

  always_comb begin
    logic [MAX_GRAM-1:0] m;
    hist_sh = {hist_r[MAX_GRAM-2:0], (c_r == 8'd0)};
    m = '0;
    nw = '0;
    for (int i = 0; i < MAX_GRAM; i++) begin
      m[i] = 1'b1;
      nw[i+1] = |(hist_sh & m);
    end

    hist_nxt  = hist_sh;
    pos_nxt   = (pos_r != {POS_W{1'b1}}) ? pos_r + POS_W'(1) : pos_r;
    seg_nxt   = seg_r;
    prev_nxt  = c_r;
    pend_nxt  = pend_r;
    ucnt_nxt  = ucnt_r;
    uneed_nxt = uneed_r;
    slots_nxt = '0;
    k1_nxt    = '0;
    k2_nxt    = '0;
    sb_nxt    = '0;
    sl_nxt    = '0;
    handled   = 1'b0;
    psh       = pend_r << 1;
    ret       = '0;

    if (ucnt_r != '0) begin
      if ((c_r[7:6] == 2'b10) && (ucnt_r < uneed_r)) begin
        handled  = 1'b1;
        ucnt_nxt = ucnt_r + CNT_W'(1);
        if (ucnt_nxt == uneed_r) begin
          slots_nxt[SLOT_SINGLE] = 1'b1;
          sb_nxt   = LEN_W'(uneed_r) - LEN_W'(1);
          sl_nxt   = LEN_W'(uneed_r);
          ucnt_nxt = '0;
        end
      end else begin
        for (int j = 0; j < 3; j++) slots_nxt[j] = (CNT_W'(j) < ucnt_r);
        k1_nxt   = ucnt_r;
        ucnt_nxt = '0;
      end
    end

    if (!handled) begin
      if (c_r[7] == 1'b0) begin
        if (seg_r < LEN_W'(MAX_GRAM)) seg_nxt = seg_r + LEN_W'(1);
        if (!mode_r) begin
          if ((seg_nxt >= n_eff) && !nw[n_eff]) begin
            slots_nxt[SLOT_SINGLE] = 1'b1;
            sb_nxt = n_eff - LEN_W'(1);
            sl_nxt = n_eff;
          end
        end else if (seg_nxt >= LEN_W'(2)) begin
          // Open starts age by one; the oldest retire at max length, and on a
          // boundary every start that has reached min length retires too.
          for (int l = 1; l <= MAX_GRAM; l++) begin
            ret[l] = psh[l] && ((LEN_W'(l) == mx_eff) || (bnd_r && (LEN_W'(l) >= n_eff)));
            slots_nxt[SLOT_RET0 + MAX_GRAM - l] = ret[l] && !nw[l];
          end
          pend_nxt = psh & ~ret;
          if (bnd_r) begin
            if (mx_eff <= LEN_W'(2)) begin
              slots_nxt[SLOT_BOUND] = (mx_eff == LEN_W'(2)) ? !nw[2] : !hist_sh[1];
            end else begin
              pend_nxt[2] = 1'b1;
            end
          end
        end
      end else begin
        seg_nxt  = '0;
        pend_nxt = '0;
        if (seq_len(c_r) == CNT_W'(1)) begin
          slots_nxt[SLOT_SINGLE] = 1'b1;
          sb_nxt = '0;
          sl_nxt = LEN_W'(1);
        end else begin
          uneed_nxt = seq_len(c_r);
          ucnt_nxt  = CNT_W'(1);
        end
      end
    end

    if (eov_r) begin
      for (int j = 0; j < 3; j++) slots_nxt[SLOT_F2 + j] = (CNT_W'(j) < ucnt_nxt);
      k2_nxt   = ucnt_nxt;
      ucnt_nxt = '0;
      seg_nxt  = '0;
      pend_nxt = '0;
      pos_nxt  = '0;
      hist_nxt = '0;
      prev_nxt = '0;
    end
  end

  // Result selection: the lowest pending slot goes out next.
  logic [NUM_SLOTS-1:0]   first_oh;
  logic [LEN_W-1:0]       e_back, e_len;
  logic                   e_hi, found;
  logic [BASE_W-1:0]      base, start;
  logic                   e_ovf;
  logic [OFFSET_BITS-1:0] e_start;

  always_comb begin
    found    = 1'b0;
    first_oh = '0;
    e_back   = '0;
    e_len    = '0;
    e_hi     = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slots_r[i] && !found) begin
        found       = 1'b1;
        first_oh[i] = 1'b1;
        if (i < SLOT_SINGLE) begin
          e_back = LEN_W'(k1_r) - LEN_W'(i);
          e_len  = LEN_W'(1);
        end else if (i == SLOT_SINGLE) begin
          e_back = sb_r;
          e_len  = sl_r;
        end else if (i < SLOT_BOUND) begin
          e_len  = LEN_W'(MAX_GRAM - (i - SLOT_RET0));
          e_back = e_len - LEN_W'(1);
        end else if (i == SLOT_BOUND) begin
          e_back = LEN_W'(1);
          e_len  = mx_eff;
        end else begin
          e_back = LEN_W'(k2_r) - LEN_W'(i - SLOT_F2);
          e_len  = LEN_W'(1);
          e_hi   = 1'b1;
        end
      end
    end
    base    = BASE_W'(step_pos_r) + BASE_W'(e_hi);
    start   = (BASE_W'(e_back) > base) ? '0 : base - BASE_W'(e_back);
    e_ovf   = start > BASE_W'({OFFSET_BITS{1'b1}});
    e_start = e_ovf ? {OFFSET_BITS{1'b1}} : start[OFFSET_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      min_len_r   <= 5'd3;
      max_len_r   <= 5'd8;
      dens_r      <= DENS_W'(100);
      fold_r      <= 1'b0;
      pos_r       <= '0;
      seg_r       <= '0;
      hist_r      <= '0;
      prev_r      <= '0;
      pend_r      <= '0;
      ucnt_r      <= '0;
      uneed_r     <= '0;
      slots_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.calc) begin
        pos_r   <= pos_nxt;
        seg_r   <= seg_nxt;
        hist_r  <= hist_nxt;
        prev_r  <= prev_nxt;
        ucnt_r  <= ucnt_nxt;
        uneed_r <= uneed_nxt;
        slots_r <= slots_nxt;
      end else if (cmd.emit) begin
        slots_r <= slots_r & ~first_oh;
      end
      if (cfg_hit) begin
        pend_r <= '0;
      end else if (cmd.calc) begin
        pend_r <= pend_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRAM_MODE: begin
            mode_r <= cfg_data[0];
          end
          REG_MIN_LENGTH: begin
            min_len_r <= cfg_data[4:0];
          end
          REG_MAX_LENGTH: begin
            max_len_r <= cfg_data[4:0];
          end
          REG_DENSITY: begin
            dens_r <= cfg_data[DENS_W-1:0];
          end
          REG_FOLD_CASE: begin
            fold_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      k1_r       <= k1_nxt;
      k2_r       <= k2_nxt;
      sb_r       <= sb_nxt;
      sl_r       <= sl_nxt;
      step_pos_r <= pos_r;
    end
    if (cmd.emit) begin
      out_start_r <= e_start;
      out_len_r   <= e_len;
      out_ovf_r   <= e_ovf;
      out_last_r  <= sts.slots_one;
    end
  end

  always_comb begin
    sts.need_hash   = mode_r && !in_text_byte[7] && (seg_r != '0);
    sts.slots_empty = (slots_r == '0);
    sts.slots_one   = ((slots_r & (slots_r - NUM_SLOTS'(1))) == '0);
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid           = out_valid_r;
  assign out_gram_start      = out_start_r;
  assign out_gram_length     = out_len_r;
  assign out_offset_overflow = out_ovf_r;
  assign out_last_of_run     = out_last_r;

endmodule
`default_nettype wire

@@ design/sparse_ngram_span_extractor_top.sv @@
// Top level of the sparse n-gram span extractor.
`timescale 1ns / 1ps
`default_nettype none
// Takes one text byte per transfer and delivers gram spans (start, length) in
// text order, one result per transfer, with last_of_run on the final result of
// each byte. An item passes the step evaluation state, then one emit state per
// result, held while the output register is full. A sparse-mode ASCII byte
// after the first of its run adds the pair hash states M0 to M4 and CMP, on
// one shared 32x32 multiplier. A finished result waits in the output register
// while the next byte is taken, and a further result waits for it to drain.
// Configuration writes are taken in any cycle and belong to idle periods.
module sparse_ngram_span_extractor_top
  import sngx_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_text_byte,
  input  wire logic                  in_end_of_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OFFSET_BITS-1:0]     out_gram_start,
  output logic [LEN_W-1:0]           out_gram_length,
  output logic                       out_offset_overflow,
  output logic                       out_last_of_run,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  sngx_cmd_t cmd;
  sngx_sts_t sts;

  assign cfg_ready = 1'b1;

  sngx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sngx_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_text_byte        (in_text_byte),
    .in_end_of_value     (in_end_of_value),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_gram_start      (out_gram_start),
    .out_gram_length     (out_gram_length),
    .out_offset_overflow (out_offset_overflow),
    .out_last_of_run     (out_last_of_run)
  );

endmodule
`default_nettype wire

@@ design/sngx_checker.sv @@
// Port-level checker for the sparse n-gram span extractor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sngx_checker
  import sngx_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [OFFSET_BITS-1:0] out_gram_start,
  input wire logic [LEN_W-1:0]       out_gram_length,
  input wire logic                   out_offset_overflow,
  input wire logic                   out_last_of_run
);

  // A byte is worked on alone: the input closes right after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a byte is still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_gram_start)
      && $stable(out_gram_length) && $stable(out_last_of_run)))
    else $error("stalled result changed");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gram_length != '0 && out_gram_length <= LEN_W'(MAX_GRAM)))
    else $error("gram length out of range");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_offset_overflow) |-> (out_gram_start == {OFFSET_BITS{1'b1}}))
    else $error("overflowed start not saturated");

endmodule

bind sparse_ngram_span_extractor_top sngx_checker u_sngx_checker (.*);
`default_nettype wire
